[rtl/core/hfbt_pkg.sv]
// shared types, codes and helpers for the heavy-flow bucket table
`timescale 1ns / 1ps
`default_nettype none

package hfbt_pkg;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam int          HALF_W     = 16;
  localparam int          MAX_SLOT_W = 4;
  localparam int          SLOT_BITS  = 128;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_REJECT = 3'd1,
    ST_LOST   = 3'd2,
    ST_HIT    = 3'd3,
    ST_MISS   = 3'd4
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] flow_id;
    logic [31:0] hash_value;
    logic [31:0] increment;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] count_value;
    logic [31:0] rejected_total;
    logic [31:0] replaced_total;
  } result_t;

  typedef struct packed {
    logic [31:0] guard;
    logic [31:0] val;
    logic [31:0] key;
    logic [31:0] fp;
  } slot_t;

  // summary of one bucket scan
  typedef struct packed {
    logic                  hit;
    logic [MAX_SLOT_W-1:0] hit_idx;
    slot_t                 hit_slot;
    logic                  empty;
    logic [MAX_SLOT_W-1:0] empty_idx;
    logic [MAX_SLOT_W-1:0] min_idx;
    slot_t                 min_slot;
    logic [31:0]           nz_min;
  } scan_res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/hfbt_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module hfbt_ram #(
  parameter int  WIDTH = 128,
  parameter int  DEPTH = 8192,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/hfbt_mod.sv]
// reciprocal-multiply remainder of two 16-bit hash halves by the bucket count
`timescale 1ns / 1ps
`default_nettype none

module hfbt_mod import hfbt_pkg::*; #(
  parameter int  BUCKETS = 1024,
  localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [HALF_W-1:0] a_i,
  input  wire logic [HALF_W-1:0] b_i,
  output logic                   done_o,
  output logic      [IDX_W-1:0]  ra_o,
  output logic      [IDX_W-1:0]  rb_o
);

  localparam int              PROD_W = HALF_W + 33;
  // ceil(2^32 / BUCKETS) gives the exact quotient for every 16-bit dividend
  localparam logic [32:0]     RECIP  =
    33'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [HALF_W:0] BKT    = (HALF_W+1)'(BUCKETS);

  logic              s1_q, s2_q, done_q;
  logic [HALF_W-1:0] xa_q, xb_q;
  logic [HALF_W-1:0] qa_q, qb_q;
  logic [IDX_W-1:0]  ra_q, rb_q;
  logic [PROD_W-1:0] pa, pb;
  logic [HALF_W-1:0] ma, mb;

  assign pa = PROD_W'(xa_q) * PROD_W'(RECIP);
  assign pb = PROD_W'(xb_q) * PROD_W'(RECIP);

  // the remainder is below BUCKETS, so the low bits of quotient times divisor suffice
  assign ma = HALF_W'({1'b0, qa_q} * BKT);
  assign mb = HALF_W'({1'b0, qb_q} * BKT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
      xa_q   <= '0;
      xb_q   <= '0;
      qa_q   <= '0;
      qb_q   <= '0;
      ra_q   <= '0;
      rb_q   <= '0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
      if (start_i) begin
        xa_q <= a_i;
        xb_q <= b_i;
      end
      if (s1_q) begin
        qa_q <= pa[HALF_W+31:32];
        qb_q <= pb[HALF_W+31:32];
      end
      if (s2_q) begin
        ra_q <= IDX_W'(xa_q - ma);
        rb_q <= IDX_W'(xb_q - mb);
      end
    end
  end

  assign done_o = done_q;
  assign ra_o   = ra_q;
  assign rb_o   = rb_q;

endmodule

`default_nettype wire

[rtl/core/hfbt_scan.sv]
// slot compare unit: folds one slot per cycle into the bucket summary
`timescale 1ns / 1ps
`default_nettype none

module hfbt_scan import hfbt_pkg::*; #(
  parameter int  SLOTS_PER_BUCKET = 8,
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic              valid_i,
  input  wire logic [SLOT_W-1:0] idx_i,
  input  wire slot_t             slot_i,
  input  wire logic [31:0]       key_i,
  input  wire logic [31:0]       fp_i,
  output scan_res_t              res_o
);

  localparam scan_res_t RES_INIT = '{
    hit:       1'b0,
    hit_idx:   '0,
    hit_slot:  '0,
    empty:     1'b0,
    empty_idx: '0,
    min_idx:   '0,
    min_slot:  '0,
    nz_min:    ALL_ONES
  };

  scan_res_t res_q;
  logic      match;

  assign match = (slot_i.key == key_i) && (slot_i.fp == fp_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_INIT;
    end else if (clr_i) begin
      res_q.hit    <= 1'b0;
      res_q.empty  <= 1'b0;
      res_q.nz_min <= ALL_ONES;
    end else if (valid_i) begin
      if (match && !res_q.hit) begin
        res_q.hit      <= 1'b1;
        res_q.hit_idx  <= MAX_SLOT_W'(idx_i);
        res_q.hit_slot <= slot_i;
      end
      if ((slot_i.val == '0) && !res_q.empty) begin
        res_q.empty     <= 1'b1;
        res_q.empty_idx <= MAX_SLOT_W'(idx_i);
      end
      // first slot seeds the minimum, later ones only on strictly lower count
      if ((idx_i == '0) || (slot_i.val < res_q.min_slot.val)) begin
        res_q.min_idx  <= MAX_SLOT_W'(idx_i);
        res_q.min_slot <= slot_i;
      end
      if ((slot_i.val != '0) && (slot_i.val < res_q.nz_min)) begin
        res_q.nz_min <= slot_i.val;
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/core/heavy_flow_bucket_table_top.sv]
// heavy-flow bucket table: sequencer, slot store and output register
// sequence: an accepted transaction passes bucket index reduction, slot scan, decision
//   and response in turn; a query that probes the secondary bucket scans and decides
//   once more before its response
// one transaction at a time: the next is accepted once the last result is registered, later while one is held
// reset: a clearing pass zeroes the slot store before the first transaction is accepted;
//   counters and threshold reset to zero
`timescale 1ns / 1ps
`default_nettype none

module heavy_flow_bucket_table_top import hfbt_pkg::*; #(
  parameter int BUCKETS          = 1024,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire item_t       in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output result_t          out_data_o
);

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DEPTH  = BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               rd_valid_q, rd_valid_d;
  logic [SLOT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]   bkt_s_q, bkt_s_d;
  logic               pass_q, pass_d;
  item_t              item_q, item_d;
  status_e            st_q, st_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        rej_q, rej_d;
  logic [31:0]        rep_q, rep_d;
  logic [31:0]        thr_q, thr_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  slot_t              ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [SLOT_BITS-1:0] ram_rdata;
  logic [SLOT_W-1:0]  wr_idx;
  logic               scan_clr;
  logic               mod_start;
  logic               mod_done;
  logic [IDX_W-1:0]   bkt_p, bkt_s;
  scan_res_t          scan_res;
  slot_t              new_slot;
  logic               vote_win;

  assign in_ready_o = (state_q == S_IDLE);
  assign mod_start  = in_valid_i && in_ready_o;

  hfbt_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .a_i     (in_data_i.hash_value[HALF_W-1:0]),
    .b_i     (in_data_i.hash_value[2*HALF_W-1:HALF_W]),
    .done_o  (mod_done),
    .ra_o    (bkt_p),
    .rb_o    (bkt_s)
  );

  hfbt_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hfbt_scan #(
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (scan_clr),
    .valid_i (rd_valid_q),
    .idx_i   (rd_idx_q),
    .slot_i  (slot_t'(ram_rdata)),
    .key_i   (item_q.flow_id),
    .fp_i    (item_q.hash_value),
    .res_o   (scan_res)
  );

  assign ram_raddr = base_q + ADDR_W'(iss_q[SLOT_W-1:0]);

  always_comb begin
    new_slot.fp    = item_q.hash_value;
    new_slot.key   = item_q.flow_id;
    new_slot.val   = item_q.increment;
    new_slot.guard = '0;
    // guard + 1 (saturating) beats the victim count
    vote_win = (scan_res.min_slot.guard == ALL_ONES) ? (scan_res.min_slot.val != ALL_ONES)
                                                     : (scan_res.min_slot.guard >=
                                                        scan_res.min_slot.val);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    iss_d       = iss_q;
    rd_valid_d  = 1'b0;
    rd_idx_d    = rd_idx_q;
    base_d      = base_q;
    bkt_s_d     = bkt_s_q;
    pass_d      = pass_q;
    item_d      = item_q;
    st_d        = st_q;
    cnt_d       = cnt_q;
    rej_d       = rej_q;
    rep_d       = rep_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    wr_idx      = '0;
    scan_clr    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (mod_start) begin
          item_d  = in_data_i;
          pass_d  = 1'b0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          base_d   = ADDR_W'(bkt_p * SLOTS_PER_BUCKET);
          bkt_s_d  = bkt_s;
          iss_d    = '0;
          scan_clr = 1'b1;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_q < CNT_W'(SLOTS_PER_BUCKET)) begin
          rd_valid_d = 1'b1;
          rd_idx_d   = iss_q[SLOT_W-1:0];
          iss_d      = iss_q + CNT_W'(1);
        end
        if (rd_valid_q && (rd_idx_q == SLOT_W'(SLOTS_PER_BUCKET - 1))) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_d   = '0;
        state_d = S_RESP;
        if (item_q.opcode == OP_INSERT) begin
          st_d = ST_OK;
          if (scan_res.hit) begin
            ram_we        = 1'b1;
            wr_idx        = scan_res.hit_idx[SLOT_W-1:0];
            ram_wdata     = scan_res.hit_slot;
            ram_wdata.val = sat_add(scan_res.hit_slot.val, item_q.increment);
          end else if (scan_res.empty) begin
            ram_we    = 1'b1;
            wr_idx    = scan_res.empty_idx[SLOT_W-1:0];
            ram_wdata = new_slot;
          end else if ((thr_q != '0) && (scan_res.min_slot.val >= thr_q)) begin
            st_d  = ST_REJECT;
            rej_d = rej_q + 32'd1;
          end else begin
            ram_we = 1'b1;
            wr_idx = scan_res.min_idx[SLOT_W-1:0];
            if (vote_win) begin
              ram_wdata = new_slot;
              rep_d     = rep_q + 32'd1;
            end else begin
              ram_wdata       = scan_res.min_slot;
              ram_wdata.guard = sat_add(scan_res.min_slot.guard, 32'd1);
              st_d            = ST_LOST;
            end
          end
        end else begin
          if (scan_res.hit) begin
            st_d  = ST_HIT;
            cnt_d = scan_res.hit_slot.val;
          end else if (!pass_q && (scan_res.nz_min >= thr_q)) begin
            // probe the secondary bucket
            pass_d   = 1'b1;
            base_d   = ADDR_W'(bkt_s_q * SLOTS_PER_BUCKET);
            iss_d    = '0;
            scan_clr = 1'b1;
            state_d  = S_SCAN;
          end else begin
            st_d = ST_MISS;
          end
        end
        ram_waddr = base_q + ADDR_W'(wr_idx);
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = st_q;
          out_d.count_value    = cnt_q;
          out_d.rejected_total = rej_q;
          out_d.replaced_total = rep_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      iss_q       <= '0;
      rd_valid_q  <= 1'b0;
      rd_idx_q    <= '0;
      base_q      <= '0;
      bkt_s_q     <= '0;
      pass_q      <= 1'b0;
      item_q      <= '0;
      st_q        <= ST_OK;
      cnt_q       <= '0;
      rej_q       <= '0;
      rep_q       <= '0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      rd_valid_q  <= rd_valid_d;
      rd_idx_q    <= rd_idx_d;
      base_q      <= base_d;
      bkt_s_q     <= bkt_s_d;
      pass_q      <= pass_d;
      item_q      <= item_d;
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      rej_q       <= rej_d;
      rep_q       <= rep_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // counters move by one at most, and never both for the same transaction
  a_rej_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rej_q != $past(rej_q)) |-> (rej_q == $past(rej_q) + 32'd1))
    else $error("rejection counter jumped");

  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rej_q != $past(rej_q)) |-> (rep_q == $past(rep_q)))
    else $error("rejection and replacement on one transaction");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !rd_valid_q)
    else $error("slot store written while a scan read is in flight");

  a_count_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_HIT)) |-> (out_data_o.count_value == '0))
    else $error("nonzero count on a result other than a query hit");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == S_SCAN))
    else $error("slot evaluated outside the scan");

endmodule

`default_nettype wire
